// ===== rtl/albm_pkg.sv =====
// shared types and constants of the audio level bar meter
package albm_pkg;

  localparam int unsigned VolW      = 12;
  localparam int unsigned BrightW   = 9;
  localparam int unsigned LevelW    = 14;
  localparam int unsigned OutIdxW   = 6;
  localparam int unsigned ChanW     = 8;

  localparam logic [VolW-1:0]    NoiseFloorReset = 12'd400;
  localparam logic [VolW-1:0]    MaxVolumeReset  = 12'd2500;
  localparam logic [BrightW-1:0] BrightReset     = 9'd256;

  localparam logic [OutIdxW-1:0] GreenEnd   = 6'd20;
  localparam logic [OutIdxW-1:0] YellowEnd  = 6'd40;
  localparam logic [6:0]         BaseLevel  = 7'd100;
  localparam logic [LevelW-1:0]  DecayStep  = 14'd512;

  // floor(x/5) == (x*52429)>>18 for every x below 2^18
  localparam logic [15:0]        Recip5      = 16'd52429;
  localparam int unsigned        Recip5Shift = 18;

  typedef enum logic [1:0] {
    CFG_NOISE_FLOOR = 2'd0,
    CFG_MAX_VOLUME  = 2'd1,
    CFG_BRIGHTNESS  = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SUM,
    ST_UPD,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic sum;
    logic upd;
    logic led_next;
  } albm_cmd_t;

  typedef struct packed {
    logic div_last;
    logic led_last;
  } albm_status_t;

endpackage

// ===== rtl/albm_ctrl.sv =====
// sequencing state machine of the bar meter
module albm_ctrl
  import albm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  albm_status_t status_i,
  output albm_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_DIV;
      ST_DIV:  if (status_i.div_last) state_d = ST_SUM;
      ST_SUM:  state_d = ST_UPD;
      ST_UPD:  state_d = ST_EMIT;
      ST_EMIT: if (out_ready_i && status_i.led_last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = (state_q == ST_IDLE);
    out_valid_o  = (state_q == ST_EMIT);
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.sum      = (state_q == ST_SUM);
    cmd_o.upd      = (state_q == ST_UPD);
    cmd_o.led_next = (state_q == ST_EMIT) && out_ready_i;
  end

endmodule

// ===== rtl/albm_dp.sv =====
// target divider, level smoothing and led colour datapath
module albm_dp
  import albm_pkg::*;
#(
  parameter int unsigned NUM_LEDS = 60
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [VolW-1:0]    noise_floor_i,
  input  logic [VolW-1:0]    max_volume_i,
  input  logic [BrightW-1:0] brightness_i,
  input  logic [VolW-1:0]    volume_i,
  input  albm_cmd_t          cmd_i,
  output albm_status_t       status_o,
  output logic [OutIdxW-1:0] led_index_o,
  output logic [ChanW-1:0]   red_o,
  output logic [ChanW-1:0]   green_o,
  output logic [ChanW-1:0]   blue_o,
  output logic [OutIdxW-1:0] bar_length_o,
  output logic               last_led_o
);

  localparam int unsigned TgtW  = $clog2(NUM_LEDS + 1);
  localparam int unsigned NumW  = VolW + TgtW;
  localparam int unsigned StepW = $clog2(NumW);
  localparam int unsigned LedW  = $clog2(NUM_LEDS);
  localparam int unsigned T256W = TgtW + 8;
  localparam int unsigned SumW  = ((T256W + 2 > LevelW) ? T256W + 2 : LevelW) + 1;
  localparam int unsigned PrW   = SumW + 18;

  logic [NumW-1:0]   quo_q;
  logic [VolW-1:0]   rem_q;
  logic [VolW-1:0]   den_q;
  logic [StepW-1:0]  step_q;
  logic              zero_q;
  logic              rise_q;
  logic [SumW-1:0]   sum_q;
  logic [LevelW-1:0] level_q;
  logic [LedW-1:0]   led_q;

  logic [VolW-1:0]   vmin;
  logic [VolW:0]     trial;
  logic              ge;
  logic [TgtW-1:0]   tgt;
  logic [T256W-1:0]  t256;
  logic [PrW-1:0]    prod;
  logic [LevelW-1:0] decayed;
  logic [OutIdxW-1:0] led_ext;
  logic [15:0]       lvl_prod;
  logic [ChanW-1:0]  on_val;
  logic              lit;

  assign vmin  = (volume_i > max_volume_i) ? max_volume_i : volume_i;
  assign trial = {rem_q, quo_q[NumW-1]};
  assign ge    = (trial >= {1'b0, den_q});
  assign tgt   = zero_q ? '0 : quo_q[TgtW-1:0];
  assign t256  = {tgt, 8'd0};
  assign prod  = PrW'(sum_q) * PrW'(Recip5);
  assign decayed = (level_q > DecayStep) ? (level_q - DecayStep) : '0;

  // control counters and smoothed level register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      led_q   <= '0;
      level_q <= '0;
    end else begin
      if (cmd_i.load) begin
        step_q <= '0;
      end else if (cmd_i.div_step) begin
        step_q <= step_q + 1'b1;
      end
      if (cmd_i.upd) begin
        led_q   <= '0;
        level_q <= rise_q ? prod[Recip5Shift +: LevelW] : decayed;
      end else if (cmd_i.led_next) begin
        led_q <= led_q + 1'b1;
      end
    end
  end

  // restoring division, one quotient bit per cycle, and smoothing sum
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      zero_q <= (volume_i <= noise_floor_i) || (max_volume_i <= noise_floor_i);
      quo_q  <= NumW'(vmin - noise_floor_i) * NumW'(NUM_LEDS);
      rem_q  <= '0;
      den_q  <= max_volume_i - noise_floor_i;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? VolW'(trial - {1'b0, den_q}) : trial[VolW-1:0];
      quo_q <= {quo_q[NumW-2:0], ge};
    end
    if (cmd_i.sum) begin
      rise_q <= SumW'(t256) > SumW'(level_q);
      sum_q  <= SumW'(level_q) + (SumW'(t256) << 2);
    end
  end

  assign status_o.div_last = (step_q == StepW'(NumW - 1));
  assign status_o.led_last = (led_q == LedW'(NUM_LEDS - 1));

  assign led_ext  = OutIdxW'(led_q);
  assign lvl_prod = 16'(BaseLevel) * 16'(brightness_i);
  assign on_val   = lvl_prod[15:8];
  assign lit      = led_ext < level_q[LevelW-1:8];

  always_comb begin
    red_o   = '0;
    green_o = '0;
    if (lit) begin
      if (led_ext < GreenEnd) begin
        green_o = on_val;
      end else if (led_ext < YellowEnd) begin
        red_o   = on_val;
        green_o = on_val;
      end else begin
        red_o   = on_val;
      end
    end
  end

  assign blue_o       = '0;
  assign led_index_o  = led_ext;
  assign bar_length_o = level_q[LevelW-1:8];
  assign last_led_o   = status_o.led_last;

endmodule

// ===== rtl/audio_level_bar_meter.sv =====
// audio level bar meter: config registers, controller and datapath
// sequence: a taken volume item runs through the divider and the sum and update states
//   before led items leave; no new volume item is taken until the last led item is taken
// rates: the divider makes one quotient bit per cycle, and led items leave one per cycle
//   while out_ready_i is high
// reset: noise floor 400, max volume 2500, brightness 256, smoothed level 0
module audio_level_bar_meter
  import albm_pkg::*;
#(
  parameter int unsigned NUM_LEDS = 60
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [VolW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [VolW-1:0]    volume_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [OutIdxW-1:0] led_index_o,
  output logic [ChanW-1:0]   red_o,
  output logic [ChanW-1:0]   green_o,
  output logic [ChanW-1:0]   blue_o,
  output logic [OutIdxW-1:0] bar_length_o,
  output logic               last_led_o
);

  logic [VolW-1:0]    noise_floor_q;
  logic [VolW-1:0]    max_volume_q;
  logic [BrightW-1:0] brightness_q;
  albm_cmd_t          cmd;
  albm_status_t       status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_floor_q <= NoiseFloorReset;
      max_volume_q  <= MaxVolumeReset;
      brightness_q  <= BrightReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_NOISE_FLOOR: noise_floor_q <= cfg_data_i;
        CFG_MAX_VOLUME:  max_volume_q  <= cfg_data_i;
        CFG_BRIGHTNESS:  brightness_q  <= cfg_data_i[BrightW-1:0];
        default: ;
      endcase
    end
  end

  albm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  albm_dp #(
    .NUM_LEDS (NUM_LEDS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .noise_floor_i (noise_floor_q),
    .max_volume_i  (max_volume_q),
    .brightness_i  (brightness_q),
    .volume_i      (volume_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .led_index_o   (led_index_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .bar_length_o  (bar_length_o),
    .last_led_o    (last_led_o)
  );

  // input and output sides are never open together
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while led items pending");

  // a taken volume item closes the input side
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input reopened right after accept");

  // the final led item frees the block
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_led_o) |=> in_ready_o)
    else $error("block not idle after final led item");

  // led items walk the strip in order without gaps
  a_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_led_o) |=>
      (out_valid_o && (led_index_o == $past(led_index_o) + 6'd1)))
    else $error("led index sequence broken");

endmodule
